/* hw/rtl/audio_channel_strip_macros.svh */
// ----------------------------------------------------------------------------
// audio_channel_strip assertion macros
// Concurrent checks on clk with the asynchronous reset as disable condition.
// ----------------------------------------------------------------------------
`ifndef AUDIO_CHANNEL_STRIP_MACROS_SVH
`define AUDIO_CHANNEL_STRIP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication check.
`define ACS_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// Next-cycle implication check.
`define ACS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define ACS_ASSERT(lbl, ante, cons)
`define ACS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/acs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Shared constants and arithmetic helpers of the audio channel strip.
// ----------------------------------------------------------------------------
package acs_pkg;

	// Parameter defaults.
	localparam int EQ_BANDS_DEF    = 4;
	localparam int HPF_STAGES_DEF  = 2;
	localparam int FRAME_MAX_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 24;

	// Fixed field widths.
	localparam int KIND_W  = 2;
	localparam int CIDX_W  = 3;
	localparam int CFG_W   = 25;
	localparam int COEF_W  = 32;
	localparam int SIG_W   = 32;
	localparam int PEAK_W  = 31;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int GAIN_W  = 18;
	localparam int STEP_W  = 19;
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 32;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COEF   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_METER  = 2'd2;

	// Register indexes.
	localparam logic [CIDX_W-1:0] REG_FLAGS   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_GAIN    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_FRAME   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_THRESH  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_ATTACK  = 3'd4;
	localparam logic [CIDX_W-1:0] REG_RELEASE = 3'd5;
	localparam logic [CIDX_W-1:0] REG_MAKEUP  = 3'd6;

	// Control flag bit positions.
	localparam int FL_MUTE   = 0;
	localparam int FL_BYPASS = 1;
	localparam int FL_HPF    = 2;
	localparam int FL_HPF2   = 3;
	localparam int FL_EQ0    = 4;
	localparam int FL_LIM    = 8;
	localparam int FL_OUTCH  = 9;
	localparam int EQ_FLAGS  = 4;

	// Register reset values and limits.
	localparam logic [GAIN_W-1:0] GAIN_UNITY = 18'd65536;
	localparam logic [GAIN_W-1:0] GAIN_MAX   = 18'd131072;
	localparam logic [23:0] THRESH_RST  = 24'd4204175;
	localparam logic [24:0] ATTACK_RST  = 25'd69760;
	localparam logic [24:0] RELEASE_RST = 25'd3495;
	localparam logic [23:0] MAKEUP_RST  = 24'd1048576;
	localparam logic [24:0] Q24_ONE     = 25'd16777216;
	localparam int FRAME_RST = 256;

	// Saturate a wide signed value to the internal signal range.
	function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] lim;
		lim = PROD_W'(64'sd2147483647);
		if (v > lim) begin
			sat_sig = SIG_W'(lim);
		end else if (v < -lim) begin
			sat_sig = SIG_W'(-lim);
		end else begin
			sat_sig = SIG_W'(v);
		end
	endfunction

	// Magnitude of a saturated internal signal.
	function automatic logic [PEAK_W-1:0] mag(input logic signed [SIG_W-1:0] v);
		logic signed [SIG_W-1:0] a;
		a = v[SIG_W-1] ? -v : v;
		mag = a[PEAK_W-1:0];
	endfunction

endpackage

/* hw/rtl/audio_channel_strip.sv */
`timescale 1ns / 1ps
// Items are taken one at a time: a new item is accepted only while idle,
// once the previous result has been loaded into the output register. The
// biquads run a five-tap MAC on the shared multiplier; the limiter and the
// gain ramp use the shared multiplier and the serial divider. Reset is
// asynchronous, active low: registers take their reset values, gain returns
// to unity, and coefficients, filter history, envelope and meters clear.
// ----------------------------------------------------------------------------
// audio_channel_strip
// Biquad high-pass and EQ chain, peak limiter, gain ramp and peak meters on
// one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
`include "audio_channel_strip_macros.svh"

module audio_channel_strip #(
	parameter int EQ_BANDS    = acs_pkg::EQ_BANDS_DEF,
	parameter int HPF_STAGES  = acs_pkg::HPF_STAGES_DEF,
	parameter int FRAME_MAX   = acs_pkg::FRAME_MAX_DEF,
	parameter int SAMPLE_BITS = acs_pkg::SAMPLE_BITS_DEF,
	localparam int IN_DATA_W  = ((SAMPLE_BITS + 38 + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((SAMPLE_BITS + 93 + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// sample_in, coef_stage, coef_slot, coef_value
	input  logic [IN_DATA_W-1:0]        s_axis_tdata,
	// kind
	input  logic [acs_pkg::KIND_W-1:0]  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// sample_out, level_peak, limiter_pre_peak, limiter_post_peak
	output logic [OUT_DATA_W-1:0]       m_axis_tdata,
	input  logic                        cfg_we,
	input  logic [acs_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [acs_pkg::CFG_W-1:0]   cfg_data
);
	import acs_pkg::*;

	localparam int NSTAGES = HPF_STAGES + EQ_BANDS;
	localparam int ST_W    = $clog2(NSTAGES);
	localparam int FL_W    = $clog2(FRAME_MAX + 1);
	localparam int POS_W   = $clog2(FRAME_MAX);
	localparam int ACC_W   = PROD_W + 1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_STAGE, ST_MAC, ST_BQEND, ST_POST, ST_LENVM, ST_LENV, ST_LDIV,
		ST_LDIVW, ST_LXMUL, ST_LT, ST_LMKMUL, ST_LOUT, ST_LMET, ST_GSTEP, ST_GDIV,
		ST_GDIVW, ST_GMUL, ST_GOUT, ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [9:0]         flags_q;
	logic [GAIN_W-1:0]  target_q;
	logic [FL_W-1:0]    frame_len_q;
	logic [23:0]        thresh_q;
	logic [24:0]        attack_q;
	logic [24:0]        release_q;
	logic [23:0]        makeup_q;

	// Channel state.
	logic signed [COEF_W-1:0] coef_q [NSTAGES][5];
	logic signed [SIG_W-1:0]  hist_q [NSTAGES][4];
	logic [PEAK_W-1:0]        env_q;
	logic [GAIN_W-1:0]        gain_cur_q;
	logic signed [STEP_W-1:0] step_q;
	logic [POS_W-1:0]         pos_q;
	logic [PEAK_W-1:0]        lvl_pk_q, pre_pk_q, post_pk_q;

	// Item and working registers.
	logic [KIND_W-1:0]        kind_q;
	logic [2:0]               cstage_q, cslot_q;
	logic signed [COEF_W-1:0] cvalue_q;
	logic signed [SIG_W-1:0]  s_q;
	logic [ST_W-1:0]          st_q;
	logic [2:0]               k_q;
	logic                     neg_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     att_q;
	logic [24:0]              gr_q;
	logic signed [MUL_W-1:0]  t_q;
	logic signed [19:0]       g_q;
	logic signed [SAMPLE_BITS-1:0] o_q;

	// Output register.
	logic                     m_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic [PEAK_W-1:0]        out_lvl_q, out_pre_q, out_post_q;

	// Shared multiplier.
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	// Divider.
	logic                     div_start;
	logic [DIV_N_W-1:0]       div_num;
	logic [DIV_D_W-1:0]       div_den;
	logic                     div_done;
	logic [DIV_N_W-1:0]       div_quo;

	// Combinational helpers.
	logic [NSTAGES-1:0]       stage_en;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic signed [SIG_W-1:0]  in_sig;
	logic [PEAK_W-1:0]        in_mag, s_mag, pk;
	logic [2:0]               k_idx;
	logic [1:0]               h_idx;
	logic signed [STEP_W-1:0] step_now;
	logic [FL_W-1:0]          pos_inc, k_frame;
	logic                     frame_end;
	logic signed [PROD_W-1:0] prod_abs;
	logic signed [PROD_W-1:0] bq_round, lim_out, t_full, g_out;
	logic signed [PROD_W-1:0] smax;
	logic [PROD_W-1:0]        env_adj;
	logic signed [19:0]       q_signed;
	logic [ST_W-1:0]          wr_stage;

	assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
	assign in_sig    = sat_sig(PROD_W'(in_sample));
	assign in_mag    = mag(in_sig);
	assign s_mag     = mag(s_q);
	assign pk        = s_mag;
	assign k_idx     = (k_q < 3'd5) ? k_q : 3'd0;
	assign h_idx     = 2'(k_idx - 3'd1);
	assign step_now  = (pos_q == '0) ?
		(STEP_W'($signed({1'b0, target_q})) - STEP_W'($signed({1'b0, gain_cur_q}))) : step_q;
	assign pos_inc   = FL_W'(pos_q) + 1'b1;
	assign k_frame   = (pos_inc > frame_len_q) ? frame_len_q : pos_inc;
	assign frame_end = pos_inc >= frame_len_q;
	assign prod_abs  = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign bq_round  = PROD_W'((acc_q + ACC_W'(64'sd134217728)) >>> 28);
	assign lim_out   = (prod_q + PROD_W'(64'sd524288)) >>> 20;
	assign t_full    = (prod_q + PROD_W'(64'sd8388608)) >>> 24;
	assign g_out     = (prod_q + PROD_W'(64'sd32768)) >>> 16;
	assign smax      = (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
	assign env_adj   = (prod_q + PROD_W'(64'sd8388608)) >> 24;
	assign q_signed  = neg_q ? -$signed({2'b00, div_quo[17:0]}) : $signed({2'b00, div_quo[17:0]});
	assign wr_stage  = ST_W'(cstage_q);

	// Stage enables: high-pass stages first, then the eq bands.
	always_comb begin
		for (int i = 0; i < NSTAGES; i++) begin
			if (i == 0) begin
				stage_en[i] = flags_q[FL_HPF];
			end else if (i == 1 && HPF_STAGES > 1) begin
				stage_en[i] = flags_q[FL_HPF] && flags_q[FL_HPF2];
			end else if (i >= HPF_STAGES && i - HPF_STAGES < EQ_FLAGS) begin
				stage_en[i] = flags_q[FL_EQ0 + ((i - HPF_STAGES) % EQ_FLAGS)];
			end else begin
				stage_en[i] = 1'b0;
			end
		end
	end

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MAC: begin
				mul_a = MUL_W'(coef_q[st_q][k_idx]);
				mul_b = (k_idx == 3'd0) ? MUL_W'(s_q) : MUL_W'(hist_q[st_q][h_idx]);
			end
			ST_LENVM: begin
				mul_a = pk > env_q ? $signed(MUL_W'(attack_q)) : $signed(MUL_W'(release_q));
				mul_b = pk > env_q ? $signed(MUL_W'(pk - env_q)) : $signed(MUL_W'(env_q - pk));
			end
			ST_LXMUL: begin
				mul_a = MUL_W'(s_q);
				mul_b = $signed(MUL_W'(gr_q));
			end
			ST_LMKMUL: begin
				mul_a = t_q;
				mul_b = $signed(MUL_W'(makeup_q));
			end
			ST_GSTEP: begin
				mul_a = MUL_W'(step_now);
				mul_b = $signed(MUL_W'(k_frame));
			end
			ST_GMUL: begin
				mul_a = MUL_W'(s_q);
				mul_b = MUL_W'(g_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Divider requests.
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		if (state_q == ST_LDIV) begin
			div_start = {1'b0, env_q} > {8'd0, thresh_q};
			div_num   = {thresh_q, 24'd0};
			div_den   = DIV_D_W'(env_q);
		end else if (state_q == ST_GDIV) begin
			div_start = 1'b1;
			div_num   = prod_abs[DIV_N_W-1:0];
			div_den   = DIV_D_W'(frame_len_q);
		end
	end

	acs_div #(
		.N_W(DIV_N_W),
		.D_W(DIV_D_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_den),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Sequencer, channel state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flags_q     <= '0;
			target_q    <= GAIN_UNITY;
			frame_len_q <= FL_W'(FRAME_RST);
			thresh_q    <= THRESH_RST;
			attack_q    <= ATTACK_RST;
			release_q   <= RELEASE_RST;
			makeup_q    <= MAKEUP_RST;
			for (int i = 0; i < NSTAGES; i++) begin
				for (int j = 0; j < 5; j++) coef_q[i][j] <= '0;
				for (int j = 0; j < 4; j++) hist_q[i][j] <= '0;
			end
			env_q      <= '0;
			gain_cur_q <= GAIN_UNITY;
			step_q     <= '0;
			pos_q      <= '0;
			lvl_pk_q   <= '0;
			pre_pk_q   <= '0;
			post_pk_q  <= '0;
			m_valid_q  <= 1'b0;
			kind_q     <= KIND_SAMPLE;
		end else begin
			if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						kind_q   <= s_axis_tuser;
						cstage_q <= s_axis_tdata[SAMPLE_BITS +: 3];
						cslot_q  <= s_axis_tdata[SAMPLE_BITS + 3 +: 3];
						cvalue_q <= s_axis_tdata[SAMPLE_BITS + 6 +: 32];
						s_q      <= in_sig;
						st_q     <= '0;
						if (s_axis_tuser != KIND_SAMPLE) begin
							state_q <= ST_DONE;
						end else if (flags_q[FL_MUTE]) begin
							// Muted: gain snaps to target, frame still advances.
							gain_cur_q <= target_q;
							step_q     <= '0;
							o_q        <= '0;
							pos_q      <= frame_end ? '0 : POS_W'(pos_inc);
							state_q    <= ST_DONE;
						end else if (flags_q[FL_BYPASS]) begin
							if (in_mag > lvl_pk_q) lvl_pk_q <= in_mag;
							state_q <= ST_GSTEP;
						end else begin
							state_q <= ST_STAGE;
						end
					end
				end
				ST_STAGE: begin
					k_q   <= '0;
					acc_q <= '0;
					if (stage_en[st_q]) begin
						state_q <= ST_MAC;
					end else if (st_q == ST_W'(NSTAGES - 1)) begin
						state_q <= ST_POST;
					end else begin
						st_q <= st_q + 1'b1;
					end
				end
				ST_MAC: begin
					// Five taps issued, each product added in the cycle after it is issued.
					neg_q <= k_q >= 3'd3;
					if (k_q != 3'd0) begin
						acc_q <= neg_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
					end
					k_q <= k_q + 1'b1;
					if (k_q == 3'd5) state_q <= ST_BQEND;
				end
				ST_BQEND: begin
					hist_q[st_q][1] <= hist_q[st_q][0];
					hist_q[st_q][0] <= s_q;
					hist_q[st_q][3] <= hist_q[st_q][2];
					hist_q[st_q][2] <= sat_sig(bq_round);
					s_q             <= sat_sig(bq_round);
					if (st_q == ST_W'(NSTAGES - 1)) begin
						state_q <= ST_POST;
					end else begin
						st_q    <= st_q + 1'b1;
						state_q <= ST_STAGE;
					end
				end
				ST_POST: begin
					if (flags_q[FL_OUTCH]) begin
						if (s_mag > pre_pk_q) pre_pk_q <= s_mag;
					end
					if (flags_q[FL_OUTCH] && flags_q[FL_LIM]) begin
						state_q <= ST_LENVM;
					end else begin
						if (flags_q[FL_OUTCH] && s_mag > post_pk_q) post_pk_q <= s_mag;
						if (s_mag > lvl_pk_q) lvl_pk_q <= s_mag;
						state_q <= ST_GSTEP;
					end
				end
				ST_LENVM: begin
					att_q   <= pk > env_q;
					state_q <= ST_LENV;
				end
				ST_LENV: begin
					env_q   <= att_q ? env_q + PEAK_W'(env_adj) : env_q - PEAK_W'(env_adj);
					state_q <= ST_LDIV;
				end
				ST_LDIV: begin
					if (div_start) begin
						state_q <= ST_LDIVW;
					end else begin
						gr_q    <= Q24_ONE;
						state_q <= ST_LXMUL;
					end
				end
				ST_LDIVW: begin
					if (div_done) begin
						gr_q    <= div_quo[24:0];
						state_q <= ST_LXMUL;
					end
				end
				ST_LXMUL: begin
					state_q <= ST_LT;
				end
				ST_LT: begin
					t_q     <= t_full[MUL_W-1:0];
					state_q <= ST_LMKMUL;
				end
				ST_LMKMUL: begin
					state_q <= ST_LOUT;
				end
				ST_LOUT: begin
					s_q     <= sat_sig(lim_out);
					state_q <= ST_LMET;
				end
				ST_LMET: begin
					if (s_mag > post_pk_q) post_pk_q <= s_mag;
					if (s_mag > lvl_pk_q) lvl_pk_q <= s_mag;
					state_q <= ST_GSTEP;
				end
				ST_GSTEP: begin
					step_q  <= step_now;
					state_q <= ST_GDIV;
				end
				ST_GDIV: begin
					neg_q   <= prod_q[PROD_W-1];
					state_q <= ST_GDIVW;
				end
				ST_GDIVW: begin
					if (div_done) begin
						g_q     <= $signed({2'b00, gain_cur_q}) + q_signed;
						state_q <= ST_GMUL;
					end
				end
				ST_GMUL: begin
					state_q <= ST_GOUT;
				end
				ST_GOUT: begin
					if (g_out > smax) begin
						o_q <= SAMPLE_BITS'(smax);
					end else if (g_out < -smax - 1) begin
						o_q <= SAMPLE_BITS'(-smax - 1);
					end else begin
						o_q <= SAMPLE_BITS'(g_out);
					end
					if (frame_end) begin
						gain_cur_q <= GAIN_W'($signed({1'b0, gain_cur_q}) + step_q);
						pos_q      <= '0;
					end else begin
						pos_q <= POS_W'(pos_inc);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Load the result once the output register is free.
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q    <= 1'b1;
						out_sample_q <= (kind_q == KIND_SAMPLE) ? o_q : '0;
						out_lvl_q    <= lvl_pk_q;
						out_pre_q    <= pre_pk_q;
						out_post_q   <= post_pk_q;
						if (kind_q == KIND_METER) begin
							lvl_pk_q  <= '0;
							pre_pk_q  <= '0;
							post_pk_q <= '0;
						end
						if (kind_q == KIND_COEF && 32'(cstage_q) < NSTAGES && cslot_q < 3'd5) begin
							coef_q[wr_stage][cslot_q] <= cvalue_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Register writes.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FLAGS: begin
						flags_q <= cfg_data[9:0];
						if (cfg_data[FL_MUTE]) begin
							gain_cur_q <= target_q;
							step_q     <= '0;
						end
						if (!cfg_data[FL_LIM]) env_q <= '0;
					end
					REG_GAIN: begin
						target_q <= (cfg_data > CFG_W'(GAIN_MAX)) ? GAIN_MAX : cfg_data[GAIN_W-1:0];
					end
					REG_FRAME: begin
						if (cfg_data == '0) begin
							frame_len_q <= FL_W'(1);
						end else if (cfg_data > CFG_W'(FRAME_MAX)) begin
							frame_len_q <= FL_W'(FRAME_MAX);
						end else begin
							frame_len_q <= cfg_data[FL_W-1:0];
						end
					end
					REG_THRESH:  thresh_q  <= cfg_data[23:0];
					REG_ATTACK:  attack_q  <= (cfg_data > Q24_ONE) ? Q24_ONE : cfg_data;
					REG_RELEASE: release_q <= (cfg_data > Q24_ONE) ? Q24_ONE : cfg_data;
					REG_MAKEUP:  makeup_q  <= cfg_data[23:0];
					default: ;
				endcase
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;

	// Pack the result.
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[SAMPLE_BITS-1:0]                  = out_sample_q;
		m_axis_tdata[SAMPLE_BITS +: PEAK_W]            = out_lvl_q;
		m_axis_tdata[SAMPLE_BITS + PEAK_W +: PEAK_W]   = out_pre_q;
		m_axis_tdata[SAMPLE_BITS + 2*PEAK_W +: PEAK_W] = out_post_q;
	end

	// Checks.
	`ACS_ASSERT(a_gain_range, 1'b1, gain_cur_q <= GAIN_MAX)
	`ACS_ASSERT(a_pos_range, 1'b1, 32'(pos_q) < FRAME_MAX)
	`ACS_ASSERT(a_result_from_done, $rose(m_valid_q), $past(state_q == ST_DONE))
	`ACS_ASSERT_NEXT(a_env_clear, cfg_we && cfg_index == REG_FLAGS && !cfg_data[FL_LIM], env_q == '0)

endmodule

/* hw/rtl/acs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acs_div #(
	parameter int N_W = acs_pkg::DIV_N_W,
	parameter int D_W = acs_pkg::DIV_D_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);
	localparam int CNT_W = $clog2(N_W + 1);

	logic [D_W:0]   rem_q;
	logic [N_W-1:0] quo_q;
	logic [D_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [D_W:0]   shifted;
	logic           fits;

	// One trial subtraction per cycle.
	assign shifted = {rem_q[D_W-1:0], quo_q[N_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
